// File: hdl/sfc_pkg.sv
package sfc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int MTX_DEPTH   = 12;
  localparam int PLANE_DEPTH = 16;

  // Recompute sequence steps
  localparam logic [4:0] STEP_RS_V   = 5'd0;
  localparam logic [4:0] STEP_COS_V  = 5'd1;
  localparam logic [4:0] STEP_RS_H   = 5'd2;
  localparam logic [4:0] STEP_PLANE0 = 5'd4;
  localparam logic [4:0] STEP_VOFF   = 5'd20;

  // Test sequence: view plane, then four side planes
  localparam logic [4:0] TEST_LAST = 5'd4;

  // Configuration register indexes
  localparam logic REG_VERT  = 1'b0;
  localparam logic REG_HORIZ = 1'b1;

  // Result codes
  localparam logic [2:0] CULL_NONE = 3'd0;
  localparam logic [2:0] CULL_VIEW = 3'd1;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_RECOMP = 2'd1,
    FUNC_TEST   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_COS,
    OP_NORM,
    OP_OFF,
    OP_VOFF,
    OP_TEST
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RS_GO,
    S_RS_WAIT,
    S_MUL,
    S_SUM,
    S_EVAL,
    S_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_SQRT,
    RS_DIV
  } rs_state_t;

  typedef enum logic {
    JOB_RECOMP,
    JOB_TEST
  } job_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         mtx_index;
    logic signed [31:0] mtx_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [30:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] cull_plane;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       rs_start;
    logic       mul_en;
    logic       sum_en;
    logic       eval_en;
    logic       out_load;
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic rs_done;
    logic reject;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/sfc_rsqrt.sv
module sfc_rsqrt
  import sfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [30:0]          tan_in,
  output logic                 done,
  output logic [FRAC_BITS:0]   s_out
);

  localparam int DIV_STEPS  = 2 * FRAC_BITS + 1;
  localparam int SQRT_STEPS = 32;
  localparam int CW         = $clog2(DIV_STEPS);

  rs_state_t            state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [63:0]          u_r, res_r, bit_r;
  logic [31:0]          rem_r;
  logic [FRAC_BITS:0]   quot_r;

  logic [61:0]          sq;
  logic [63:0]          trial;
  logic                 num_bit;
  logic [32:0]          rem2, diff;
  logic                 ge;

  assign sq      = tan_in * tan_in;
  assign trial   = res_r + bit_r;
  assign num_bit = (cnt_r == '0);
  assign rem2    = {rem_r, num_bit};
  assign diff    = rem2 - {1'b0, res_r[31:0]};
  assign ge      = (rem2 >= {1'b0, res_r[31:0]});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      RS_IDLE: begin
        if (start) begin
          state_nxt = RS_SQRT;
          cnt_nxt   = '0;
        end
      end
      RS_SQRT: begin
        if (cnt_r == CW'(SQRT_STEPS - 1)) begin
          state_nxt = RS_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      RS_DIV: begin
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          state_nxt = RS_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = RS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // One root bit per cycle, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state_r)
      RS_IDLE: begin
        if (start) begin
          u_r   <= {2'b00, sq} + (64'd1 << (2 * FRAC_BITS));
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      RS_SQRT: begin
        if (u_r >= trial) begin
          u_r   <= u_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        rem_r  <= '0;
        quot_r <= '0;
      end
      RS_DIV: begin
        rem_r  <= ge ? diff[31:0] : rem2[31:0];
        quot_r <= {quot_r[FRAC_BITS-1:0], ge};
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign s_out = quot_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == RS_IDLE)
    else $error("rsqrt started while busy");

endmodule

// File: hdl/sfc_datapath.sv
module sfc_datapath
  import sfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  in_item_t    in_data,
  input  logic [30:0] vert_tan,
  input  logic [30:0] horiz_tan,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int SUMW = 66;
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-31){1'b1}}, {31{1'b0}}};

  logic signed [31:0]     mtx_r   [MTX_DEPTH];
  logic signed [31:0]     plane_r [PLANE_DEPTH];
  logic signed [31:0]     voff_r;
  logic [FRAC_BITS:0]     sv_r, sh_r;
  logic [30:0]            cv_r, ch_r;
  logic signed [31:0]     pt_r [3];
  logic [30:0]            rad_r;
  logic signed [63:0]     prod_r [3];
  logic signed [SUMW-1:0] sum_r;
  logic [2:0]             code_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [30:0]            t_sel;
  logic [FRAC_BITS:0]     rs_s;
  logic                   rs_done;

  logic signed [31:0]     op_a [3];
  logic signed [31:0]     op_b [3];
  logic signed [31:0]     off_sel;
  logic signed [31:0]     sh_ext, sv_ext, ch_ext, cv_ext, s_ext;
  logic [1:0]             pl, cp, tq;
  logic [3:0]             ra_idx, rb_idx;
  logic signed [SUMW-1:0] dot, lhs;
  logic signed [31:0]     sat_v;
  logic                   reject;

  assign t_sel = cmd.idx[0] ? horiz_tan : vert_tan;

  sfc_rsqrt #(.FRAC_BITS(FRAC_BITS)) u_rsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.rs_start),
    .tan_in (t_sel),
    .done   (rs_done),
    .s_out  (rs_s)
  );

  assign sh_ext = signed'({{(31-FRAC_BITS){1'b0}}, sh_r});
  assign sv_ext = signed'({{(31-FRAC_BITS){1'b0}}, sv_r});
  assign s_ext  = signed'({{(31-FRAC_BITS){1'b0}}, rs_s});
  assign ch_ext = signed'({1'b0, ch_r});
  assign cv_ext = signed'({1'b0, cv_r});

  assign pl     = cmd.idx[3:2];
  assign cp     = cmd.idx[1:0];
  assign tq     = 2'(cmd.idx - 5'd1);
  assign ra_idx = (pl[1] ? 4'd3 : 4'd0) + {2'b00, cp};
  assign rb_idx = 4'd6 + {2'b00, cp};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    off_sel = voff_r;
    case (cmd.op)
      OP_COS: begin
        op_a[0] = signed'({1'b0, t_sel});
        op_b[0] = s_ext;
      end
      OP_NORM: begin
        case (pl)
          2'd0:    op_a[0] = -sh_ext;
          2'd1:    op_a[0] = sh_ext;
          2'd2:    op_a[0] = sv_ext;
          default: op_a[0] = -sv_ext;
        endcase
        op_a[1] = pl[1] ? cv_ext : ch_ext;
        op_b[0] = mtx_r[ra_idx];
        op_b[1] = mtx_r[rb_idx];
      end
      OP_OFF: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = plane_r[{pl, 2'(i)}];
          op_b[i] = mtx_r[4'(9 + i)];
        end
      end
      OP_VOFF: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = mtx_r[4'(6 + i)];
          op_b[i] = mtx_r[4'(9 + i)];
        end
      end
      OP_TEST: begin
        for (int i = 0; i < 3; i++) begin
          op_b[i] = pt_r[i];
          op_a[i] = (cmd.idx == 5'd0) ? mtx_r[4'(6 + i)] : plane_r[{tq, 2'(i)}];
        end
        off_sel = (cmd.idx == 5'd0) ? voff_r : plane_r[{tq, 2'd3}];
      end
      default: ;
    endcase
  end

  // Floor to the fixed point and saturate
  assign dot    = sum_r >>> FRAC_BITS;
  assign sat_v  = (dot > SMAX) ? 32'sh7FFF_FFFF :
                  (dot < SMIN) ? 32'sh8000_0000 : dot[31:0];
  assign lhs    = SUMW'(off_sel) + SUMW'(signed'({1'b0, rad_r}));
  assign reject = (lhs < dot);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= op_a[i] * op_b[i];
      end
    end
    if (cmd.sum_en) begin
      sum_r <= SUMW'(prod_r[0]) + SUMW'(prod_r[1]) + SUMW'(prod_r[2]);
    end
    if (cmd.load) begin
      if (in_data.func == FUNC_WRITE && in_data.mtx_index < 4'(MTX_DEPTH)) begin
        mtx_r[in_data.mtx_index] <= in_data.mtx_value;
      end
      pt_r[0] <= in_data.point_x;
      pt_r[1] <= in_data.point_y;
      pt_r[2] <= in_data.point_z;
      rad_r   <= in_data.radius;
      code_r  <= CULL_NONE;
    end
    if (cmd.eval_en) begin
      case (cmd.op)
        OP_COS: begin
          if (cmd.idx[0]) begin
            sh_r <= rs_s;
            ch_r <= dot[30:0];
          end else begin
            sv_r <= rs_s;
            cv_r <= dot[30:0];
          end
        end
        OP_TEST: begin
          if (reject) begin
            code_r <= CULL_VIEW + cmd.idx[2:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r.visible    <= (code_r == CULL_NONE);
      out_data_r.cull_plane <= code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_DEPTH; i++) begin
        plane_r[i] <= '0;
      end
      voff_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval_en && (cmd.op == OP_NORM || cmd.op == OP_OFF)) begin
        plane_r[cmd.idx[3:0]] <= sat_v;
      end
      if (cmd.eval_en && cmd.op == OP_VOFF) begin
        voff_r <= sat_v;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.rs_done  = rs_done;
  assign sts.reject   = reject;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/sfc_ctrl.sv
module sfc_ctrl
  import sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  job_t       job_r, job_nxt;
  logic       accept;
  logic [4:0] pidx;

  assign accept = in_valid && (state_r == S_IDLE);
  assign pidx   = step_r - STEP_PLANE0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_RECOMP: state_nxt = S_RS_GO;
            FUNC_TEST:   state_nxt = S_MUL;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RS_GO:   state_nxt = S_RS_WAIT;
      S_RS_WAIT: if (sts.rs_done) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_EVAL;
      S_EVAL: begin
        if (job_r == JOB_TEST) begin
          state_nxt = (sts.reject || step_r == TEST_LAST) ? S_OUT : S_MUL;
        end else if (step_r == STEP_VOFF) begin
          state_nxt = S_IDLE;
        end else if (step_r == STEP_COS_V) begin
          state_nxt = S_RS_GO;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Step counter and job
  always_comb begin
    step_nxt = step_r;
    job_nxt  = job_r;
    if (accept) begin
      step_nxt = STEP_RS_V;
      job_nxt  = (in_func == FUNC_TEST) ? JOB_TEST : JOB_RECOMP;
    end else if (state_r == S_RS_WAIT && sts.rs_done) begin
      step_nxt = step_r + 5'd1;
    end else if (state_r == S_EVAL) begin
      step_nxt = step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      job_r   <= JOB_RECOMP;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      job_r   <= job_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_stall     = (state_r != S_IDLE);
    cmd.load     = accept;
    cmd.rs_start = (state_r == S_RS_GO);
    cmd.mul_en   = (state_r == S_MUL);
    cmd.sum_en   = (state_r == S_SUM);
    cmd.eval_en  = (state_r == S_EVAL);
    cmd.out_load = (state_r == S_OUT) && sts.out_free;
    if (job_r == JOB_TEST) begin
      cmd.op  = OP_TEST;
      cmd.idx = step_r;
    end else if (step_r == STEP_VOFF) begin
      cmd.op  = OP_VOFF;
      cmd.idx = '0;
    end else if (step_r >= STEP_PLANE0) begin
      cmd.op  = (pidx[1:0] == 2'd3) ? OP_OFF : OP_NORM;
      cmd.idx = pidx;
    end else begin
      cmd.op  = OP_COS;
      cmd.idx = {4'b0000, step_r[1]};
    end
  end

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rs_done |-> state_r == S_RS_WAIT)
    else $error("rsqrt finished outside wait state");

  a_test_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && job_r == JOB_TEST) |-> step_r <= TEST_LAST)
    else $error("test ran past the last plane");

  a_rs_wait_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RS_WAIT |-> (job_r == JOB_RECOMP &&
                              (step_r == STEP_RS_V || step_r == STEP_RS_H)))
    else $error("rsqrt wait at wrong step");

endmodule

// File: hdl/sphere_frustum_cull_unit.sv
// Five-plane sphere culling against a 4x3 camera matrix, signed fixed point.
// Input channel (in_valid / in_stall / in_data) carries one item per command:
//   write matrix element, recompute planes, or test a sphere. Write items
//   finish in the accept cycle. A recompute holds the input while the
//   bit-serial square root and reciprocal unit, shared by both tangents,
//   runs for each tangent and while each plane term passes through the
//   shared three-lane dot-product unit.
// A test walks the view, left, right, top and bottom planes with that unit,
//   each plane through multiply, sum and compare states, and stops at the
//   first plane that rejects. The result is then loaded into the output
//   register once it is free, and out_valid rises with that load.
// Only tests produce a result item. The block takes one item at a time; the
//   next item is taken while a finished result still waits in the output
//   register. With out_stall held high a second test holds in its last state.
// The APB port holds the two tangent registers (byte addresses 0 and 4);
//   write them only while the block is idle. pready is always high.
// Reset clears the planes, the view offset and all control, and sets both
//   tangents to 1.0. Matrix elements are undefined until written.
module sphere_frustum_cull_unit
  import sfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [30:0] TAN_ONE = 31'(1) << FRAC_BITS;

  logic [30:0] vert_r, horiz_r;
  logic        wr_en;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_r  <= TAN_ONE;
      horiz_r <= TAN_ONE;
    end else if (wr_en) begin
      if (paddr[2] == REG_VERT) begin
        vert_r <= pwdata[30:0];
      end
      if (paddr[2] == REG_HORIZ) begin
        horiz_r <= pwdata[30:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HORIZ) ? {1'b0, horiz_r} : {1'b0, vert_r};

  sfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .vert_tan  (vert_r),
    .horiz_tan (horiz_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
